// File: rtl/tis_pkg.sv
// ----------------------------------------------------------------------------
// tis_pkg
// shared types, widths and register codes of the triangle isoline block
// ----------------------------------------------------------------------------
package tis_pkg;

    localparam int COORD_BITS = 16;
    localparam int VAL_BITS   = 16;
    localparam int MAX_LEVELS = 16;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 4;
    localparam int LVL_W      = 22;
    localparam int MAG_W      = VAL_BITS;
    localparam int TQ_W       = VAL_BITS + 1;
    localparam int DIV_STEPS  = TQ_W;
    localparam int DELTA_W    = COORD_BITS + 1;
    localparam int PROD_W     = DELTA_W + TQ_W + 1;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = 2;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_STEP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 2'd2;

    typedef struct packed {
        logic signed [VAL_BITS-1:0]   v;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] x;
    } corner_t;

    typedef struct packed {
        corner_t [2:0]            c;
        logic signed [LVL_W-1:0]  level;
        logic [IDX_W-1:0]         idx;
        logic                     last;
        logic [2:0]               above;
    } job_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] xa;
        logic signed [COORD_BITS-1:0] ya;
        logic signed [DELTA_W-1:0]    dx;
        logic signed [DELTA_W-1:0]    dy;
    } edge_t;

    typedef struct packed {
        edge_t            e0;
        edge_t            e1;
        logic [IDX_W-1:0] idx;
        logic             last;
    } side_t;

    function automatic logic signed [LVL_W-1:0] sext_val(input logic signed [VAL_BITS-1:0] v);
        sext_val = {{(LVL_W-VAL_BITS){v[VAL_BITS-1]}}, v};
    endfunction

endpackage

// File: rtl/triangle_isoline_segments.sv
// ----------------------------------------------------------------------------
// triangle_isoline_segments
// contour segments of one triangle against evenly spaced levels
// ----------------------------------------------------------------------------
// s_axis carries one triangle per transfer; m_axis carries one segment per
// transfer, tlast set on the last segment of a triangle. a triangle with no
// crossing level produces no transfer.
// the front walks one level per cycle unless a crossing level finds the
// queue full, and the next triangle is taken in the cycle the last level
// is checked.
// crossing levels go through a four-entry queue into the back pipeline,
// two restoring dividers with one quotient bit per stage plus a multiply and
// an add stage, giving one segment per cycle while m_axis_tready is high.
// the cfg channel is always ready; write only while the block is idle.
// reset restores level_first 0, level_step 256, level_count 2 and empties the
// pipeline. the back pipeline holds while m_axis_tvalid is high and tready low;
// a full queue holds the front at a crossing level, with s_axis_tready low.
// ----------------------------------------------------------------------------
module triangle_isoline_segments (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // corner0_x, corner0_y, corner0_value, corner1_x, corner1_y,
    // corner1_value, corner2_x, corner2_y, corner2_value
    input  logic [143:0]                      s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // level_index, start_x, start_y, end_x, end_y, zero fill
    output logic [71:0]                       m_axis_tdata,
    output logic                              m_axis_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tis_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [15:0]                       cfg_data
);

    logic signed [tis_pkg::VAL_BITS-1:0] first_reg;
    logic [tis_pkg::VAL_BITS-1:0]        step_reg;
    logic [tis_pkg::CNT_W-1:0]           count_reg;
    tis_pkg::corner_t [2:0]              in_tri;
    tis_pkg::job_t                       push_job, pop_job;
    logic                                push, pop, full, empty;
    logic [tis_pkg::IDX_W-1:0]           o_idx;
    logic signed [tis_pkg::COORD_BITS-1:0] o_sx, o_sy, o_ex, o_ey;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= '0;
            step_reg  <= 16'd256;
            count_reg <= 5'd2;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tis_pkg::CFG_LEVEL_FIRST: first_reg <= cfg_data;
                tis_pkg::CFG_LEVEL_STEP:  step_reg  <= cfg_data;
                tis_pkg::CFG_LEVEL_COUNT: count_reg <= cfg_data[tis_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            in_tri[k].x = s_axis_tdata[48*k      +: 16];
            in_tri[k].y = s_axis_tdata[48*k + 16 +: 16];
            in_tri[k].v = s_axis_tdata[48*k + 32 +: 16];
        end
    end

    tis_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_tri(in_tri),
        .level_first(first_reg), .level_step(step_reg), .level_count(count_reg),
        .push(push), .job(push_job), .full(full)
    );

    tis_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(push), .push_job(push_job), .full(full),
        .pop(pop), .pop_job(pop_job), .empty(empty)
    );

    tis_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job(pop_job), .job_valid(!empty), .pop(pop),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_idx(o_idx), .out_sx(o_sx), .out_sy(o_sy), .out_ex(o_ex), .out_ey(o_ey),
        .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = {4'b0000, o_ey, o_ex, o_sy, o_sx, o_idx};

endmodule

// File: rtl/tis_front.sv
// ----------------------------------------------------------------------------
// tis_front
// walks the contour levels of one triangle and queues the crossing ones
// ----------------------------------------------------------------------------
module tis_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  tis_pkg::corner_t [2:0]              in_tri,
    input  logic signed [tis_pkg::VAL_BITS-1:0] level_first,
    input  logic [tis_pkg::VAL_BITS-1:0]        level_step,
    input  logic [tis_pkg::CNT_W-1:0]           level_count,
    output logic                                push,
    output tis_pkg::job_t                       job,
    input  logic                                full
);

    logic                                  busy_reg, busy_next;
    logic [tis_pkg::IDX_W-1:0]             idx_reg, idx_next;
    logic signed [tis_pkg::LVL_W-1:0]      level_reg, level_next;
    tis_pkg::corner_t [2:0]                tri_reg;
    logic [tis_pkg::CNT_W-1:0]             n_eff;
    logic signed [tis_pkg::LVL_W-1:0]      level_up;
    logic [2:0]                            above, above_up;
    logic                                  crossing, crossing_up, last_i, go, done, accept;

    assign n_eff = (level_count > tis_pkg::CNT_W'(tis_pkg::MAX_LEVELS))
                 ? tis_pkg::CNT_W'(tis_pkg::MAX_LEVELS) : level_count;
    assign level_up = level_reg + $signed({{(tis_pkg::LVL_W-tis_pkg::VAL_BITS){1'b0}}, level_step});

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            above[k]    = tis_pkg::sext_val(tri_reg[k].v) >= level_reg;
            above_up[k] = tis_pkg::sext_val(tri_reg[k].v) >= level_up;
        end
    end

    assign crossing    = (above != 3'b000) && (above != 3'b111);
    assign crossing_up = (above_up != 3'b000) && (above_up != 3'b111);
    assign last_i   = ({1'b0, idx_reg} == (n_eff - tis_pkg::CNT_W'(1)));
    assign go       = busy_reg && (!crossing || !full);
    assign done     = go && last_i;
    assign in_ready = !busy_reg || done;
    assign accept   = in_valid && in_ready;
    assign push     = busy_reg && crossing && !full;

    assign job.c     = tri_reg;
    assign job.level = level_reg;
    assign job.idx   = idx_reg;
    assign job.last  = last_i || !crossing_up;
    assign job.above = above;

    always_comb
    begin
        busy_next  = busy_reg;
        idx_next   = idx_reg;
        level_next = level_reg;
        if (go)
        begin
            idx_next   = idx_reg + tis_pkg::IDX_W'(1);
            level_next = level_up;
        end
        if (done)
            busy_next = 1'b0;
        if (accept)
        begin
            busy_next  = (n_eff != '0);
            idx_next   = '0;
            level_next = tis_pkg::sext_val(level_first);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        level_reg <= level_next;
        if (accept)
            tri_reg <= in_tri;
    end

endmodule

// File: rtl/tis_queue.sv
// ----------------------------------------------------------------------------
// tis_queue
// short job queue between the level walker and the interpolation pipeline
// ----------------------------------------------------------------------------
module tis_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tis_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output tis_pkg::job_t pop_job,
    output logic          empty
);

    tis_pkg::job_t                 mem_reg [tis_pkg::Q_DEPTH];
    logic [tis_pkg::Q_PTR_W-1:0]   wr_reg, rd_reg;
    logic [tis_pkg::Q_PTR_W:0]     cnt_reg;

    assign full    = (cnt_reg == (tis_pkg::Q_PTR_W+1)'(tis_pkg::Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign pop_job = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + tis_pkg::Q_PTR_W'(1);
            if (pop)
                rd_reg <= rd_reg + tis_pkg::Q_PTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + (tis_pkg::Q_PTR_W+1)'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - (tis_pkg::Q_PTR_W+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_job;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty)) else $error("queue underflow");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (tis_pkg::Q_PTR_W+1)'(tis_pkg::Q_DEPTH)) else $error("queue count");
    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + (tis_pkg::Q_PTR_W+1)'(1)))
        else $error("queue count step");

endmodule

// File: rtl/tis_div.sv
// ----------------------------------------------------------------------------
// tis_div
// pipelined restoring divider, one quotient bit per stage, for the fraction t
// ----------------------------------------------------------------------------
module tis_div (
    input  logic                        clk,
    input  logic                        en,
    input  logic [tis_pkg::MAG_W-1:0]   num,
    input  logic [tis_pkg::MAG_W-1:0]   den,
    output logic [tis_pkg::TQ_W-1:0]    quo
);

    logic [tis_pkg::MAG_W-1:0] r_reg [tis_pkg::DIV_STEPS+1];
    logic [tis_pkg::MAG_W-1:0] d_reg [tis_pkg::DIV_STEPS+1];
    logic [tis_pkg::TQ_W-1:0]  q_reg [tis_pkg::DIV_STEPS+1];
    logic [tis_pkg::MAG_W-1:0] r_next [tis_pkg::DIV_STEPS+1];
    logic [tis_pkg::TQ_W-1:0]  q_next [tis_pkg::DIV_STEPS+1];

    always_comb
    begin
        logic [tis_pkg::MAG_W:0] trial;
        logic                    ge;
        r_next[0] = num;
        q_next[0] = '0;
        for (int s = 1; s <= tis_pkg::DIV_STEPS; s++)
        begin
            // first step compares unshifted since the numerator never exceeds the divisor
            trial = (s == 1) ? {1'b0, r_reg[s-1]} : {r_reg[s-1], 1'b0};
            ge    = trial >= {1'b0, d_reg[s-1]};
            r_next[s] = ge ? tis_pkg::MAG_W'(trial - {1'b0, d_reg[s-1]})
                           : tis_pkg::MAG_W'(trial);
            q_next[s] = {q_reg[s-1][tis_pkg::TQ_W-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg[0] <= den;
            for (int s = 0; s <= tis_pkg::DIV_STEPS; s++)
            begin
                r_reg[s] <= r_next[s];
                q_reg[s] <= q_next[s];
                if (s > 0)
                    d_reg[s] <= d_reg[s-1];
            end
        end
    end

    assign quo = q_reg[tis_pkg::DIV_STEPS];

endmodule

// File: rtl/tis_back.sv
// ----------------------------------------------------------------------------
// tis_back
// interpolates both endpoints of each queued level and drives the result
// ----------------------------------------------------------------------------
module tis_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  tis_pkg::job_t                         job,
    input  logic                                  job_valid,
    output logic                                  pop,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [tis_pkg::IDX_W-1:0]             out_idx,
    output logic signed [tis_pkg::COORD_BITS-1:0] out_sx,
    output logic signed [tis_pkg::COORD_BITS-1:0] out_sy,
    output logic signed [tis_pkg::COORD_BITS-1:0] out_ex,
    output logic signed [tis_pkg::COORD_BITS-1:0] out_ey,
    output logic                                  out_last
);

    localparam int N = tis_pkg::DIV_STEPS;

    logic                 en;
    logic                 vld_reg [N+1];
    tis_pkg::side_t       side_reg [N+1];
    tis_pkg::side_t       side_in, side_m_reg;
    logic                 vld_m_reg, out_valid_reg;
    logic [tis_pkg::MAG_W-1:0] num0, den0, num1, den1;
    logic [tis_pkg::TQ_W-1:0]  t0, t1;
    logic signed [tis_pkg::PROD_W-1:0] px0_reg, py0_reg, px1_reg, py1_reg;
    logic [tis_pkg::IDX_W-1:0]             idx_o_reg;
    logic signed [tis_pkg::COORD_BITS-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic                                  last_o_reg;
    logic [1:0] a0, b0, a1, b1;

    assign en  = !out_valid_reg || out_ready;
    assign pop = en && job_valid;

    function automatic tis_pkg::edge_t mk_edge(input tis_pkg::corner_t ca,
                                               input tis_pkg::corner_t cb);
        mk_edge.xa = ca.x;
        mk_edge.ya = ca.y;
        mk_edge.dx = $signed({cb.x[tis_pkg::COORD_BITS-1], cb.x})
                   - $signed({ca.x[tis_pkg::COORD_BITS-1], ca.x});
        mk_edge.dy = $signed({cb.y[tis_pkg::COORD_BITS-1], cb.y})
                   - $signed({ca.y[tis_pkg::COORD_BITS-1], ca.y});
    endfunction

    function automatic logic [tis_pkg::MAG_W-1:0] mag_num(input logic signed [tis_pkg::LVL_W-1:0] lv,
                                                          input tis_pkg::corner_t ca);
        logic signed [tis_pkg::LVL_W-1:0] d;
        d = lv - tis_pkg::sext_val(ca.v);
        mag_num = d[tis_pkg::LVL_W-1] ? tis_pkg::MAG_W'(-d) : tis_pkg::MAG_W'(d);
    endfunction

    function automatic logic [tis_pkg::MAG_W-1:0] mag_den(input tis_pkg::corner_t ca,
                                                          input tis_pkg::corner_t cb);
        logic signed [tis_pkg::VAL_BITS:0] d;
        d = $signed({cb.v[tis_pkg::VAL_BITS-1], cb.v}) - $signed({ca.v[tis_pkg::VAL_BITS-1], ca.v});
        mag_den = d[tis_pkg::VAL_BITS] ? tis_pkg::MAG_W'(-d) : tis_pkg::MAG_W'(d);
    endfunction

    always_comb
    begin
        // crossed edges in order 0-1, 1-2, 2-0
        if (job.above[0] != job.above[1])
        begin
            a0 = 2'd0;
            b0 = 2'd1;
            if (job.above[1] != job.above[2])
            begin
                a1 = 2'd1;
                b1 = 2'd2;
            end
            else
            begin
                a1 = 2'd2;
                b1 = 2'd0;
            end
        end
        else
        begin
            a0 = 2'd1;
            b0 = 2'd2;
            a1 = 2'd2;
            b1 = 2'd0;
        end
        side_in.e0   = mk_edge(job.c[a0], job.c[b0]);
        side_in.e1   = mk_edge(job.c[a1], job.c[b1]);
        side_in.idx  = job.idx;
        side_in.last = job.last;
        num0 = mag_num(job.level, job.c[a0]);
        den0 = mag_den(job.c[a0], job.c[b0]);
        num1 = mag_num(job.level, job.c[a1]);
        den1 = mag_den(job.c[a1], job.c[b1]);
    end

    tis_div u_div0 (.clk(clk), .en(en), .num(num0), .den(den0), .quo(t0));
    tis_div u_div1 (.clk(clk), .en(en), .num(num1), .den(den1), .quo(t1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= N; s++)
                vld_reg[s] <= 1'b0;
            vld_m_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= job_valid;
            for (int s = 1; s <= N; s++)
                vld_reg[s] <= vld_reg[s-1];
            vld_m_reg     <= vld_reg[N];
            out_valid_reg <= vld_m_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int s = 1; s <= N; s++)
                side_reg[s] <= side_reg[s-1];
            side_m_reg <= side_reg[N];
            px0_reg <= side_reg[N].e0.dx * $signed({1'b0, t0});
            py0_reg <= side_reg[N].e0.dy * $signed({1'b0, t0});
            px1_reg <= side_reg[N].e1.dx * $signed({1'b0, t1});
            py1_reg <= side_reg[N].e1.dy * $signed({1'b0, t1});
            idx_o_reg  <= side_m_reg.idx;
            last_o_reg <= side_m_reg.last;
            sx_reg <= side_m_reg.e0.xa + px0_reg[16 +: tis_pkg::COORD_BITS];
            sy_reg <= side_m_reg.e0.ya + py0_reg[16 +: tis_pkg::COORD_BITS];
            ex_reg <= side_m_reg.e1.xa + px1_reg[16 +: tis_pkg::COORD_BITS];
            ey_reg <= side_m_reg.e1.ya + py1_reg[16 +: tis_pkg::COORD_BITS];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_idx   = idx_o_reg;
    assign out_sx    = sx_reg;
    assign out_sy    = sy_reg;
    assign out_ex    = ex_reg;
    assign out_ey    = ey_reg;
    assign out_last  = last_o_reg;

endmodule
